[hdl/adam_parameter_update_top_assert.svh]
// Assertion macros for the Adam parameter update block.
// Included by the top level; depends on no other file.
`ifndef ADAM_PARAMETER_UPDATE_TOP_ASSERT_SVH
`define ADAM_PARAMETER_UPDATE_TOP_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define APU_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define APU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/apu_pkg.sv]
// Package for the Adam parameter update block: sequencer states and constants.
// Used by the channel interfaces and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package apu_pkg;

    // Payload widths of the channels.
    localparam int OP_W    = 2;
    localparam int IDX_W   = 10;
    localparam int DATA_W  = 32;
    localparam int CIDX_W  = 4;

    // Operation codes. Codes other than load and apply read the entry back.
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPLY = 2'd1;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_FIRST_DECAY    = 4'd0;
    localparam logic [CIDX_W-1:0] CFG_SECOND_DECAY   = 4'd1;
    localparam logic [CIDX_W-1:0] CFG_LEARNING_RATE  = 4'd2;
    localparam logic [CIDX_W-1:0] CFG_STABILITY_TERM = 4'd3;

    // Register reset values.
    localparam logic [31:0] RST_FIRST_DECAY    = 32'd1932735283;
    localparam logic [31:0] RST_SECOND_DECAY   = 32'd2145336164;
    localparam logic [23:0] RST_LEARNING_RATE  = 24'd16777;
    localparam logic [15:0] RST_STABILITY_TERM = 16'd2684;

    // One in unsigned Q1.31.
    localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_RD,
        S_PW1,
        S_PW2,
        S_PW3,
        S_M1,
        S_M2,
        S_M3,
        S_SQ,
        S_V1,
        S_V2,
        S_D1I,
        S_D1,
        S_D2I,
        S_D2,
        S_RTI,
        S_ROOT,
        S_SMUL,
        S_D3I,
        S_D3,
        S_UPD,
        S_WRITE,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

[hdl/apu_if.sv]
// Channel interfaces of the Adam parameter update block: request, result, config.
// Depends on apu_pkg for the payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface apu_req_if;
    logic                             valid;
    logic                             ready;
    logic [apu_pkg::OP_W-1:0]         op;
    logic [apu_pkg::IDX_W-1:0]        index;
    logic signed [apu_pkg::DATA_W-1:0] value;
    logic                             pass_start;
    modport source(output valid, op, index, value, pass_start, input ready);
    modport sink(input valid, op, index, value, pass_start, output ready);
endinterface

interface apu_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [apu_pkg::IDX_W-1:0]        entry;
    logic signed [apu_pkg::DATA_W-1:0] param_value;
    modport source(output valid, entry, param_value, input ready);
    modport sink(input valid, entry, param_value, output ready);
endinterface

interface apu_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [apu_pkg::CIDX_W-1:0]  index;
    logic [apu_pkg::DATA_W-1:0]  data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/adam_parameter_update_top.sv]
// Adam optimizer update over a store of parameters with per-entry moments.
// Depends on apu_pkg, the interfaces in apu_if.sv and the assertion header.
//
//   channel  modport  payload                              request taken when
//   i_req    sink     op, index, value, pass_start         valid && ready
//   o_rsp    source   entry, param_value                   valid && ready
//   i_cfg    sink     index, data                          valid (ready held high)
//
// A load request passes through S_WRITE, and a read or out-of-range request through S_RD, before its result shows.
// An apply request steps through a state sequence that shares one 33x33 multiplier
// and one compare-subtract unit: three restoring divisions (31, 36 and 32 steps) and a
// 32-step square root. A division that saturates at its opening compare, or the last
// one with a zero divisor, skips its steps. pass_start adds the power update states.
// i_rst_n is synchronous; the stores are not cleared. The result register holds
// until o_rsp is taken, and no request is accepted before then.
`timescale 1ns / 1ps
`default_nettype none

module adam_parameter_update_top #(
    parameter int PARAM_COUNT = 1024
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    apu_req_if.sink     i_req,
    apu_rsp_if.source   o_rsp,
    apu_cfg_if.sink     i_cfg
);

    // Sequencer state.
    apu_pkg::t_state r_state, n_state;

    // Captured request.
    logic [9:0]         r_idx;
    logic signed [31:0] r_g;
    logic               r_inr;

    // Configuration and decay powers.
    logic [31:0] r_b1, r_b2, r_pow1, r_pow2;
    logic [23:0] r_eta;
    logic [15:0] r_eps;

    // Entry stores and their read registers.
    logic signed [31:0] r_param_mem  [0:PARAM_COUNT-1];
    logic signed [31:0] r_first_mem  [0:PARAM_COUNT-1];
    logic [31:0]        r_second_mem [0:PARAM_COUNT-1];
    logic signed [31:0] r_p_rd, r_m_rd;
    logic [31:0]        r_v_rd;

    // Arithmetic registers.
    logic signed [65:0] r_prod, r_acc;
    logic signed [31:0] r_m;
    logic [30:0]        r_sq;
    logic [31:0]        r_v;
    logic [30:0]        r_mhat;
    logic [31:0]        r_s;
    logic [34:0]        r_rem;
    logic [35:0]        r_quo;
    logic [63:0]        r_num;
    logic [5:0]         r_cnt;
    logic [31:0]        r_den;
    logic signed [31:0] r_result;

    // Shared unit operands and results.
    logic signed [32:0] mul_a, mul_b;
    logic [39:0]        cs_a, cs_b;
    logic [40:0]        cs_diff;
    logic               cs_ge;

    logic        req_acc;
    logic        req_inr;
    logic signed [32:0] g_ext, gm;
    logic signed [65:0] sum, sum_sh, sq_sh;
    logic signed [31:0] m_sat;
    logic [30:0]        sq_sat;
    logic [31:0]        v_sat;
    logic [31:0]        c1, c2, mmag;
    logic [54:0]        stp_prod;
    logic [34:0]        div_rem0, rem2_div, rem2_root;
    logic [63:0]        div_num0;
    logic [31:0]        div_den0;
    logic [5:0]         div_cnt0;
    logic [35:0]        div_cap;
    logic [36:0]        t_sum;
    logic [35:0]        t_sat;
    logic signed [33:0] p_new;
    logic signed [31:0] p_sat;
    logic               in_div, in_dinit;

    assign req_acc = i_req.valid && i_req.ready;
    assign req_inr = 32'(i_req.index) < PARAM_COUNT;

    // Configuration writes; decays above one are clamped to one.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1  <= apu_pkg::RST_FIRST_DECAY;
            r_b2  <= apu_pkg::RST_SECOND_DECAY;
            r_eta <= apu_pkg::RST_LEARNING_RATE;
            r_eps <= apu_pkg::RST_STABILITY_TERM;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                apu_pkg::CFG_FIRST_DECAY: begin
                    r_b1 <= (i_cfg.data > apu_pkg::ONE_Q31) ? apu_pkg::ONE_Q31 : i_cfg.data;
                end
                apu_pkg::CFG_SECOND_DECAY: begin
                    r_b2 <= (i_cfg.data > apu_pkg::ONE_Q31) ? apu_pkg::ONE_Q31 : i_cfg.data;
                end
                apu_pkg::CFG_LEARNING_RATE: begin
                    r_eta <= i_cfg.data[23:0];
                end
                apu_pkg::CFG_STABILITY_TERM: begin
                    r_eps <= i_cfg.data[15:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Entry stores: read on acceptance, written once at the end of a load or an in-range apply.
    always_ff @(posedge i_clk) begin
        if (req_acc && req_inr) begin
            r_p_rd <= r_param_mem[i_req.index];
            r_m_rd <= r_first_mem[i_req.index];
            r_v_rd <= r_second_mem[i_req.index];
        end
        if (r_state == apu_pkg::S_WRITE) begin
            r_param_mem[r_idx]  <= r_result;
            r_first_mem[r_idx]  <= r_m;
            r_second_mem[r_idx] <= r_v;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            apu_pkg::S_IDLE: begin
                if (req_acc) begin
                    if (i_req.op == apu_pkg::OP_APPLY && i_req.pass_start) begin
                        n_state = apu_pkg::S_PW1;
                    end else if (i_req.op == apu_pkg::OP_APPLY && req_inr) begin
                        n_state = apu_pkg::S_M1;
                    end else if (i_req.op == apu_pkg::OP_LOAD && req_inr) begin
                        n_state = apu_pkg::S_WRITE;
                    end else begin
                        n_state = apu_pkg::S_RD;
                    end
                end
            end
            apu_pkg::S_RD:   n_state = apu_pkg::S_OUT;
            apu_pkg::S_PW1:  n_state = apu_pkg::S_PW2;
            apu_pkg::S_PW2:  n_state = apu_pkg::S_PW3;
            apu_pkg::S_PW3:  n_state = r_inr ? apu_pkg::S_M1 : apu_pkg::S_RD;
            apu_pkg::S_M1:   n_state = apu_pkg::S_M2;
            apu_pkg::S_M2:   n_state = apu_pkg::S_M3;
            apu_pkg::S_M3:   n_state = apu_pkg::S_SQ;
            apu_pkg::S_SQ:   n_state = apu_pkg::S_V1;
            apu_pkg::S_V1:   n_state = apu_pkg::S_V2;
            apu_pkg::S_V2:   n_state = apu_pkg::S_D1I;
            apu_pkg::S_D1I:  n_state = cs_ge ? apu_pkg::S_D2I : apu_pkg::S_D1;
            apu_pkg::S_D1:   n_state = (r_cnt == 6'd0) ? apu_pkg::S_D2I : apu_pkg::S_D1;
            apu_pkg::S_D2I:  n_state = cs_ge ? apu_pkg::S_RTI : apu_pkg::S_D2;
            apu_pkg::S_D2:   n_state = (r_cnt == 6'd0) ? apu_pkg::S_RTI : apu_pkg::S_D2;
            apu_pkg::S_RTI:  n_state = apu_pkg::S_ROOT;
            apu_pkg::S_ROOT: n_state = (r_cnt == 6'd0) ? apu_pkg::S_SMUL : apu_pkg::S_ROOT;
            apu_pkg::S_SMUL: n_state = apu_pkg::S_D3I;
            apu_pkg::S_D3I: begin
                n_state = (r_s == 32'd0 || cs_ge) ? apu_pkg::S_UPD : apu_pkg::S_D3;
            end
            apu_pkg::S_D3:   n_state = (r_cnt == 6'd0) ? apu_pkg::S_UPD : apu_pkg::S_D3;
            apu_pkg::S_UPD:  n_state = apu_pkg::S_WRITE;
            apu_pkg::S_WRITE: n_state = apu_pkg::S_OUT;
            apu_pkg::S_OUT:  n_state = o_rsp.ready ? apu_pkg::S_IDLE : apu_pkg::S_OUT;
            default:         n_state = apu_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= apu_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Handshake outputs.
    always_comb begin
        i_req.ready       = (r_state == apu_pkg::S_IDLE);
        o_rsp.valid       = (r_state == apu_pkg::S_OUT);
        o_rsp.entry       = r_idx;
        o_rsp.param_value = r_result;
    end

    // Helper values shared by several states.
    always_comb begin
        g_ext  = {r_g[31], r_g};
        gm     = g_ext[32] ? -g_ext : g_ext;
        sum    = r_acc + r_prod;
        sum_sh = sum >>> 31;
        sq_sh  = (r_prod + 66'sd134217728) >>> 28;
        if (sum_sh > 66'sd2147483647) begin
            m_sat = 32'sh7FFF_FFFF;
        end else if (sum_sh < -66'sd2147483648) begin
            m_sat = 32'sh8000_0000;
        end else begin
            m_sat = sum_sh[31:0];
        end
        sq_sat = (sq_sh > 66'sd2147483647) ? 31'h7FFF_FFFF : sq_sh[30:0];
        v_sat  = (sum_sh > 66'sd2147483647) ? 32'h7FFF_FFFF : sum_sh[31:0];
        c1     = apu_pkg::ONE_Q31 - r_pow1;
        c2     = apu_pkg::ONE_Q31 - r_pow2;
        if (c1 == 32'd0) c1 = apu_pkg::ONE_Q31;
        if (c2 == 32'd0) c2 = apu_pkg::ONE_Q31;
        mmag     = r_m[31] ? (~r_m + 32'd1) : r_m;
        stp_prod = r_prod[54:0];
        t_sum    = {1'b0, r_quo} + 37'(r_eps);
        t_sat    = t_sum[36] ? 36'hF_FFFF_FFFF : t_sum[35:0];
        if (r_m[31]) begin
            p_new = 34'(r_p_rd) + $signed({1'b0, r_quo[32:0]});
        end else begin
            p_new = 34'(r_p_rd) - $signed({1'b0, r_quo[32:0]});
        end
        if (p_new > 34'sd2147483647) begin
            p_sat = 32'sh7FFF_FFFF;
        end else if (p_new < -34'sd2147483648) begin
            p_sat = 32'sh8000_0000;
        end else begin
            p_sat = p_new[31:0];
        end
    end

    // Division setup: quotient width, leading remainder and saturation cap.
    always_comb begin
        div_rem0 = '0;
        div_num0 = '0;
        div_den0 = c1;
        div_cnt0 = 6'd30;
        div_cap  = 36'h0_7FFF_FFFF;
        case (r_state)
            apu_pkg::S_D1I: begin
                div_rem0 = 35'(mmag);
            end
            apu_pkg::S_D2I: begin
                div_rem0 = 35'(r_v[31:5]);
                div_num0 = {r_v[4:0], 59'd0};
                div_den0 = c2;
                div_cnt0 = 6'd35;
                div_cap  = 36'hF_FFFF_FFFF;
            end
            apu_pkg::S_D3I: begin
                div_rem0 = 35'(stp_prod[54:28]);
                div_num0 = {stp_prod[27:0], 36'd0};
                div_den0 = r_s;
                div_cnt0 = 6'd31;
                div_cap  = 36'h1_0000_0000;
            end
            default: begin
            end
        endcase
    end

    // Shared multiplier operands.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            apu_pkg::S_PW1: begin
                mul_a = {1'b0, r_pow1};
                mul_b = {1'b0, r_b1};
            end
            apu_pkg::S_PW2: begin
                mul_a = {1'b0, r_pow2};
                mul_b = {1'b0, r_b2};
            end
            apu_pkg::S_M1: begin
                mul_a = {1'b0, r_b1};
                mul_b = {r_m_rd[31], r_m_rd};
            end
            apu_pkg::S_M2: begin
                mul_a = {1'b0, apu_pkg::ONE_Q31 - r_b1};
                mul_b = g_ext;
            end
            apu_pkg::S_M3: begin
                mul_a = gm;
                mul_b = gm;
            end
            apu_pkg::S_SQ: begin
                mul_a = {1'b0, r_b2};
                mul_b = {1'b0, r_v_rd};
            end
            apu_pkg::S_V1: begin
                mul_a = {1'b0, apu_pkg::ONE_Q31 - r_b2};
                mul_b = {2'b00, r_sq};
            end
            apu_pkg::S_SMUL: begin
                mul_a = {2'b00, r_mhat};
                mul_b = {9'd0, r_eta};
            end
            default: begin
            end
        endcase
    end

    // Shared compare-subtract unit: division steps, square root steps and
    // the overflow check that opens each division.
    assign in_dinit  = (r_state == apu_pkg::S_D1I) || (r_state == apu_pkg::S_D2I)
                    || (r_state == apu_pkg::S_D3I);
    assign in_div    = (r_state == apu_pkg::S_D1) || (r_state == apu_pkg::S_D2)
                    || (r_state == apu_pkg::S_D3);
    assign rem2_div  = {r_rem[33:0], r_num[63]};
    assign rem2_root = {r_rem[32:0], r_num[63:62]};

    always_comb begin
        if (in_dinit) begin
            cs_a = 40'(div_rem0);
            cs_b = 40'(div_den0);
        end else if (in_div) begin
            cs_a = 40'(rem2_div);
            cs_b = 40'(r_den);
        end else begin
            cs_a = 40'(rem2_root);
            cs_b = 40'({r_quo[31:0], 2'b01});
        end
        cs_diff = {1'b0, cs_a} - {1'b0, cs_b};
        cs_ge   = !cs_diff[40];
    end

    // Decay powers advance when an apply request carries pass_start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pow1 <= apu_pkg::ONE_Q31;
            r_pow2 <= apu_pkg::ONE_Q31;
        end else if (r_state == apu_pkg::S_PW2) begin
            r_pow1 <= r_prod[62:31];
        end else if (r_state == apu_pkg::S_PW3) begin
            r_pow2 <= r_prod[62:31];
        end
    end

    // Datapath registers, stepped by the sequencer.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (r_state)
            apu_pkg::S_IDLE: begin
                if (req_acc) begin
                    r_idx    <= i_req.index;
                    r_g      <= i_req.value;
                    r_inr    <= req_inr;
                    r_result <= i_req.value;
                    r_m      <= '0;
                    r_v      <= '0;
                end
            end
            apu_pkg::S_RD: begin
                r_result <= r_inr ? r_p_rd : 32'sd0;
            end
            apu_pkg::S_M2: begin
                r_acc <= r_prod + 66'sd1073741824;
            end
            apu_pkg::S_M3: begin
                r_m <= m_sat;
            end
            apu_pkg::S_SQ: begin
                r_sq <= sq_sat;
            end
            apu_pkg::S_V1: begin
                r_acc <= r_prod + 66'sd1073741824;
            end
            apu_pkg::S_V2: begin
                r_v <= v_sat;
            end
            apu_pkg::S_D1I, apu_pkg::S_D2I, apu_pkg::S_D3I: begin
                if (r_state == apu_pkg::S_D2I) begin
                    r_mhat <= r_quo[30:0];
                end
                if (r_state == apu_pkg::S_D3I && r_s == 32'd0) begin
                    r_quo <= '0;
                end else if (cs_ge) begin
                    r_quo <= div_cap;
                end else begin
                    r_quo <= '0;
                    r_rem <= div_rem0;
                    r_num <= div_num0;
                    r_den <= div_den0;
                    r_cnt <= div_cnt0;
                end
            end
            apu_pkg::S_D1, apu_pkg::S_D2, apu_pkg::S_D3: begin
                r_rem <= cs_ge ? cs_diff[34:0] : rem2_div;
                r_quo <= {r_quo[34:0], cs_ge};
                r_num <= {r_num[62:0], 1'b0};
                r_cnt <= r_cnt - 6'd1;
            end
            apu_pkg::S_RTI: begin
                r_num <= {t_sat, 28'd0};
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= 6'd31;
            end
            apu_pkg::S_ROOT: begin
                r_rem <= cs_ge ? cs_diff[34:0] : rem2_root;
                r_quo <= {r_quo[34:0], cs_ge};
                r_num <= {r_num[61:0], 2'b00};
                r_cnt <= r_cnt - 6'd1;
            end
            apu_pkg::S_SMUL: begin
                r_s <= r_quo[31:0];
            end
            apu_pkg::S_UPD: begin
                r_result <= p_sat;
            end
            default: begin
            end
        endcase
    end

    // Assertions.
    `include "adam_parameter_update_top_assert.svh"

    `APU_ASSERT_ALWAYS(a_out_blocks_in, i_clk, i_rst_n, !(o_rsp.valid && i_req.ready), "result pending while accepting")
    `APU_ASSERT_ALWAYS(a_pow_bound, i_clk, i_rst_n, (r_pow1 <= apu_pkg::ONE_Q31) && (r_pow2 <= apu_pkg::ONE_Q31), "decay power above one")
    `APU_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, req_acc, r_state != apu_pkg::S_IDLE, "sequencer stayed idle after a request")
    `APU_ASSERT_NEXT(a_write_to_out, i_clk, i_rst_n, r_state == apu_pkg::S_WRITE, o_rsp.valid, "store write not followed by result")

endmodule

`default_nettype wire

[tb/adam_parameter_update_top_tb.sv]
// Self-checking testbench for the Adam parameter update block.
// Depends on apu_pkg, the channel interfaces in apu_if.sv and the top level.
`timescale 1ns / 1ps

module adam_parameter_update_top_tb;

    // Read codes beside the package ones, and a register index the block ignores.
    localparam logic [apu_pkg::OP_W-1:0]   OP_READ    = 2'd2;
    localparam logic [apu_pkg::OP_W-1:0]   OP_SPARE   = 2'd3;
    localparam logic [apu_pkg::CIDX_W-1:0] CFG_UNUSED = 4'd9;
    localparam int                ENTRIES    = 1024;
    localparam int                STALL_LIMIT = 20000;
    localparam longint            Q31        = 64'sd2147483648;
    localparam longint unsigned   ROOT_MAX   = 64'd68719476735;

    logic i_clk;
    logic i_rst_n;

    apu_req_if req_ch ();
    apu_rsp_if rsp_ch ();
    apu_cfg_if cfg_ch ();

    adam_parameter_update_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    typedef struct packed {
        logic [apu_pkg::IDX_W-1:0]  entry;
        logic [apu_pkg::DATA_W-1:0] param_value;
    } t_param_result;

    // Holds the predicted results in order and compares each returned one.
    class param_result_book;
        t_param_result pending_results[$];
        int            mismatches = 0;

        task report(input string what);
            $display("MISMATCH: %s", what);
            mismatches++;
        endtask

        function void note_request(input t_param_result r);
            pending_results = {pending_results, r};
        endfunction

        task check_result(input logic [apu_pkg::IDX_W-1:0] entry,
                          input logic [apu_pkg::DATA_W-1:0] value);
            t_param_result exp_r;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result entry %0d value %h", entry, value));
            end else begin
                exp_r = pending_results.pop_front();
                if (entry !== exp_r.entry)
                    report($sformatf("entry %0d, expected %0d", entry, exp_r.entry));
                if (value !== exp_r.param_value)
                    report($sformatf("entry %0d value %h, expected %h",
                                     exp_r.entry, value, exp_r.param_value));
            end
        endtask
    endclass

    param_result_book book;

    // Shadow state of the optimizer.
    logic signed [31:0] shadow_param [ENTRIES];
    logic signed [31:0] shadow_first [ENTRIES];
    logic [31:0]        shadow_second [ENTRIES];
    bit                 loaded [ENTRIES];
    longint unsigned    power1, power2;
    longint             beta1, beta2;
    longint unsigned    eta, eps;

    bit calm;
    int quiet_cycles = 0;

    function automatic logic [31:0] sat32(input longint x);
        if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (x < -64'sd2147483648) return 32'h8000_0000;
        return x[31:0];
    endfunction

    function automatic longint unsigned int_root(input longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // One gradient step on entry k; returns the new parameter.
    function automatic logic [31:0] adam_step(input int k, input logic signed [31:0] g);
        longint m, p;
        longint unsigned gm, sq, v, c1, c2, mmag, mhat, vhat, t, s, step;
        m = beta1 * longint'(shadow_first[k]) + (Q31 - beta1) * longint'(g)
            + 64'sd1073741824;
        shadow_first[k] = sat32(m >>> 31);
        gm = (g < 0) ? longint'(-longint'(g)) : longint'(g);
        sq = (gm * gm + 64'd134217728) >> 28;
        if (sq > 64'h7FFF_FFFF) sq = 64'h7FFF_FFFF;
        v = (longint'(beta2) * longint'({32'd0, shadow_second[k]})
             + longint'(Q31 - beta2) * sq + 64'd1073741824) >> 31;
        if (v > 64'h7FFF_FFFF) v = 64'h7FFF_FFFF;
        shadow_second[k] = v[31:0];
        c1 = 64'd2147483648 - power1;
        c2 = 64'd2147483648 - power2;
        if (c1 == 0) c1 = 64'd2147483648;
        if (c2 == 0) c2 = 64'd2147483648;
        m = longint'(shadow_first[k]);
        mmag = (m < 0) ? longint'(-m) : longint'(m);
        mhat = (mmag << 31) / c1;
        if (mhat > 64'h7FFF_FFFF) mhat = 64'h7FFF_FFFF;
        vhat = (v << 31) / c2;
        if (vhat > ROOT_MAX) vhat = ROOT_MAX;
        t = vhat + eps;
        if (t > ROOT_MAX) t = ROOT_MAX;
        s = int_root(t << 28);
        step = 0;
        if (s != 0) begin
            step = ((mhat * eta) << 4) / s;
            if (step > 64'd4294967296) step = 64'd4294967296;
        end
        p = longint'(shadow_param[k]);
        if (m >= 0) p = p - longint'(step);
        else p = p + longint'(step);
        shadow_param[k] = sat32(p);
        return shadow_param[k];
    endfunction

    // Expected result of one accepted request, updating the shadow state.
    function automatic t_param_result adam_predict(input logic [apu_pkg::OP_W-1:0] op,
            input logic [apu_pkg::IDX_W-1:0] idx, input logic signed [31:0] val,
            input logic ps);
        t_param_result r;
        int k;
        k = int'(idx);
        if (op == apu_pkg::OP_APPLY && ps) begin
            power1 = (power1 * longint'(beta1)) >> 31;
            power2 = (power2 * longint'(beta2)) >> 31;
        end
        r.entry = idx;
        if (op == apu_pkg::OP_LOAD) begin
            shadow_param[k] = val;
            shadow_first[k] = 0;
            shadow_second[k] = 0;
            loaded[k] = 1;
            r.param_value = val;
        end else if (op == apu_pkg::OP_APPLY) begin
            r.param_value = adam_step(k, val);
        end else begin
            r.param_value = shadow_param[k];
        end
        return r;
    endfunction

    // Clock.
    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // Result side: check each taken result and stall at random.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            book.check_result(rsp_ch.entry, rsp_ch.param_value);
        rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 34);
    end

    // Watchdog on cycles in which no request of any channel is taken.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_req(input logic [apu_pkg::OP_W-1:0] op,
                            input logic [apu_pkg::IDX_W-1:0] idx,
                            input logic [31:0] val, input logic ps);
        // Idle for a random number of cycles before presenting the request.
        while (!calm && $urandom_range(99) < 34) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.op         <= op;
        req_ch.index      <= idx;
        req_ch.value      <= val;
        req_ch.pass_start <= ps;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        book.note_request(adam_predict(op, idx, val, ps));
    endtask

    // Lets every outstanding result come back with the sender parked.
    task automatic drain;
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (book.pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [apu_pkg::CIDX_W-1:0] idx, input logic [31:0] data);
        longint unsigned d;
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
        d = {32'd0, data};
        if (d > 64'd2147483648) d = 64'd2147483648;
        case (idx)
            apu_pkg::CFG_FIRST_DECAY:    beta1 = longint'(d);
            apu_pkg::CFG_SECOND_DECAY:   beta2 = longint'(d);
            apu_pkg::CFG_LEARNING_RATE:  eta = {40'd0, data[23:0]};
            apu_pkg::CFG_STABILITY_TERM: eps = {48'd0, data[15:0]};
            default: ;
        endcase
    endtask

    task automatic cfg_all(input logic [31:0] b1, input logic [31:0] b2,
                           input logic [31:0] lr, input logic [31:0] ep);
        cfg_write(apu_pkg::CFG_FIRST_DECAY, b1);
        cfg_write(apu_pkg::CFG_SECOND_DECAY, b2);
        cfg_write(apu_pkg::CFG_LEARNING_RATE, lr);
        cfg_write(apu_pkg::CFG_STABILITY_TERM, ep);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 4095) - 2048;
            3: return {{8{$urandom_range(1) == 1}}, 24'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    // Random requests on loaded entries; unloaded entries get a load instead.
    task automatic random_burst(input int count, input int pause_at);
        logic [apu_pkg::OP_W-1:0]  op;
        logic [apu_pkg::IDX_W-1:0] idx;
        int sel;
        for (int n = 0; n < count; n++) begin
            if (n == pause_at) drain;
            idx = ($urandom_range(9) < 8) ? apu_pkg::IDX_W'($urandom_range(31))
                                          : apu_pkg::IDX_W'($urandom);
            sel = $urandom_range(99);
            if (!loaded[idx] || sel < 10) op = apu_pkg::OP_LOAD;
            else if (sel < 70) op = apu_pkg::OP_APPLY;
            else if (sel < 90) op = OP_READ;
            else op = OP_SPARE;
            send_req(op, idx, pick_value(), $urandom_range(9) == 0);
        end
    endtask

    initial begin
        book = new();
        calm = 0;
        power1 = 64'd2147483648;
        power2 = 64'd2147483648;
        beta1 = longint'(apu_pkg::RST_FIRST_DECAY);
        beta2 = longint'(apu_pkg::RST_SECOND_DECAY);
        eta = longint'(apu_pkg::RST_LEARNING_RATE);
        eps = longint'(apu_pkg::RST_STABILITY_TERM);
        for (int k = 0; k < ENTRIES; k++) loaded[k] = 0;
        i_rst_n = 0;
        req_ch.valid = 0;
        req_ch.op = apu_pkg::OP_LOAD;
        req_ch.index = 0;
        req_ch.value = 0;
        req_ch.pass_start = 0;
        cfg_ch.valid = 0;
        cfg_ch.index = apu_pkg::CFG_FIRST_DECAY;
        cfg_ch.data = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes at reset settings, and updates with no pass seen yet.
        send_req(apu_pkg::OP_LOAD, 10'd0, 32'h7FFF_FFFF, 1'b1);
        send_req(apu_pkg::OP_LOAD, 10'd1023, 32'h8000_0000, 1'b0);
        send_req(apu_pkg::OP_LOAD, 10'd1, 32'd0, 1'b0);
        send_req(OP_READ, 10'd0, 32'hFFFF_FFFF, 1'b1);
        send_req(OP_SPARE, 10'd1023, 32'd0, 1'b1);
        send_req(apu_pkg::OP_APPLY, 10'd0, 32'd0, 1'b0);
        send_req(apu_pkg::OP_APPLY, 10'd1023, 32'h8000_0000, 1'b0);
        send_req(apu_pkg::OP_APPLY, 10'd0, 32'h7FFF_FFFF, 1'b1);
        send_req(apu_pkg::OP_APPLY, 10'd1, 32'h8000_0000, 1'b1);
        send_req(apu_pkg::OP_APPLY, 10'd1, 32'h7FFF_FFFF, 1'b0);
        send_req(OP_READ, 10'd1, 32'd0, 1'b0);
        drain;

        // Directed: beta of one, decay writes above one, zero epsilon gives a zero root.
        cfg_all(32'h8000_0000, 32'hFFFF_FFFF, 32'h00FF_FFFF, 32'd0);
        cfg_write(CFG_UNUSED, 32'hDEAD_BEEF);
        send_req(apu_pkg::OP_LOAD, 10'd5, 32'h0123_4567, 1'b0);
        send_req(apu_pkg::OP_APPLY, 10'd5, 32'd0, 1'b1);
        send_req(apu_pkg::OP_APPLY, 10'd5, 32'h1000_0000, 1'b1);
        send_req(apu_pkg::OP_APPLY, 10'd0, 32'hF000_0000, 1'b0);
        drain;

        // Directed: zero decays and zero learning rate.
        cfg_all(32'd0, 32'd0, 32'd0, 32'h0000_FFFF);
        send_req(apu_pkg::OP_APPLY, 10'd5, 32'h7FFF_FFFF, 1'b1);
        send_req(apu_pkg::OP_APPLY, 10'd1023, 32'h0000_0001, 1'b0);
        drain;

        // Random phases over several settings.
        cfg_all(apu_pkg::RST_FIRST_DECAY, apu_pkg::RST_SECOND_DECAY,
                32'(apu_pkg::RST_LEARNING_RATE), 32'(apu_pkg::RST_STABILITY_TERM));
        random_burst(280, 140);
        drain;
        cfg_all(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        calm = 1;
        random_burst(120, -1);
        calm = 0;
        random_burst(160, -1);
        drain;
        cfg_all(32'd0, 32'd0, 32'h00FF_FFFF, 32'd0);
        random_burst(280, -1);
        drain;
        for (int ph = 0; ph < 3; ph++) begin
            cfg_all($urandom, $urandom, $urandom, $urandom);
            cfg_write(apu_pkg::CFG_FIRST_DECAY,
                      $urandom_range(32'h7000_0000, 32'h7FFF_FFFF));
            cfg_write(apu_pkg::CFG_LEARNING_RATE, $urandom_range(0, 1 << 20));
            random_burst(280, -1);
            drain;
        end

        // Final wait: drain also covers the tail latency.
        if (book.pending_results.size() != 0)
            book.report("results still expected at the end");
        repeat (200) @(posedge i_clk);
        if (book.mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
